/* sv/first_fit_block_allocator_core_defines.svh */
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FFBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");
// next-cycle implication
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FFBA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define FFBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* sv/ffba_pkg.sv */
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 24;
    localparam int STATUS_W = 2;
    localparam int CFG_INDEX_W = 8;

    // table word: [23:0] data bytes, [55:24] header offset, [56] free mark
    localparam int WORD_W = SIZE_W + ADDR_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_LIMIT = 8'd1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_END  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

endpackage

/* sv/ffba_ram.sv */
module ffba_ram #(
    parameter int WIDTH = ffba_pkg::WORD_W,
    parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/first_fit_block_allocator_core.sv */
// First-fit heap allocator with an implicit block list. An allocate request
// walks the block table in address order and reuses the first free block that
// is large enough (its size is kept, no splitting); otherwise a new block is
// appended at the heap end, failing with "table full" or "heap limit". A free
// request looks the block up by its data address and marks it free; address 0
// is ignored. The block table sits in one RAM with a registered read port and
// the walk reads one entry per cycle. The finished result sits in an output
// register, so the next request can be accepted while it waits; a stalled
// receiver holds each later result back until the previous one has been
// taken. Heap base and limit are written through the configuration channel;
// the user must write them only while no request is in flight. The block
// itself does not enforce this.
`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // request_size[23:0], release_address[55:24]
    input  logic [0:0]  s_tuser,   // op[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data_address[31:0]
    output logic [2:0]  m_tuser,   // status[1:0], reused[2]

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int ABITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW    = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = ffba_pkg::ADDR_W;
    localparam int SW    = ffba_pkg::SIZE_W;
    localparam int WW    = ffba_pkg::WORD_W;
    localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    ffba_pkg::state_t state_reg, state_next;

    logic [AW-1:0] base_reg, limit_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_inc;
    logic [AW-1:0] used_reg, used_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg, pend_next;

    logic          op_reg;
    logic [SW-1:0] req_reg;
    logic [AW-1:0] rel_reg;

    logic [AW-1:0]                   res_addr_reg, res_addr_next;
    logic [ffba_pkg::STATUS_W-1:0]   res_st_reg, res_st_next;
    logic                            res_reuse_reg, res_reuse_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg;
    logic [2:0]  out_user_reg;

    logic             ram_we;
    logic [ABITS-1:0] ram_waddr, ram_raddr;
    logic [WW-1:0]    ram_wdata, ram_rdata;

    logic [SW-1:0] rd_bytes;
    logic [AW-1:0] rd_off;
    logic          rd_free;
    logic [AW-1:0] rd_daddr;
    logic [CW-1:0] chk_idx;
    logic          issue, hit, accept, out_load;
    logic [AW+1:0] need;

    ffba_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ffba_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign rd_bytes = ram_rdata[SW-1:0];
    assign rd_off   = ram_rdata[SW+AW-1:SW];
    assign rd_free  = ram_rdata[WW-1];
    assign rd_daddr = base_reg + rd_off + HDR;
    assign chk_idx  = CW'(idx_reg - 1'b1);
    assign issue    = (idx_reg < count_reg);
    assign need     = {2'b00, used_reg} + {2'b00, HDR} + (AW+2)'(req_reg);
    assign ram_raddr = idx_reg[ABITS-1:0];
    assign count_inc = CW'(count_reg + 1'b1);

    always_comb begin
        if (op_reg == ffba_pkg::OP_ALLOC) begin
            hit = pend_reg && rd_free && (rd_bytes >= req_reg);
        end else begin
            hit = pend_reg && (rd_daddr == rel_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        res_addr_next  = res_addr_reg;
        res_st_next    = res_st_reg;
        res_reuse_next = res_reuse_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx[ABITS-1:0];
        ram_wdata      = {op_reg, rd_off, rd_bytes};
        out_load       = 1'b0;

        unique case (state_reg)
            ffba_pkg::S_IDLE: begin
                if (accept) begin
                    idx_next       = '0;
                    pend_next      = 1'b0;
                    res_addr_next  = '0;
                    res_st_next    = ffba_pkg::ST_OK;
                    res_reuse_next = 1'b0;
                    // null free: nothing to look up
                    if (s_tuser[0] == ffba_pkg::OP_FREE && s_tdata[55:24] == '0) begin
                        state_next = ffba_pkg::S_OUT;
                    end else begin
                        state_next = ffba_pkg::S_WALK;
                    end
                end
            end
            ffba_pkg::S_WALK: begin
                pend_next = issue;
                if (issue) begin
                    idx_next = CW'(idx_reg + 1'b1);
                end
                if (hit) begin
                    // write back the entry with its new free mark
                    ram_we         = 1'b1;
                    res_st_next    = ffba_pkg::ST_OK;
                    res_reuse_next = (op_reg == ffba_pkg::OP_ALLOC);
                    res_addr_next  = (op_reg == ffba_pkg::OP_ALLOC) ? rd_daddr : '0;
                    state_next     = ffba_pkg::S_OUT;
                end else if (!issue) begin
                    state_next = ffba_pkg::S_END;
                end
            end
            ffba_pkg::S_END: begin
                res_addr_next  = '0;
                res_reuse_next = 1'b0;
                if (op_reg == ffba_pkg::OP_FREE) begin
                    res_st_next = ffba_pkg::ST_UNKNOWN;
                end else if (count_reg == CNT_MAX) begin
                    res_st_next = ffba_pkg::ST_FULL;
                end else if (need > {2'b00, limit_reg}) begin
                    res_st_next = ffba_pkg::ST_LIMIT;
                end else begin
                    // append a new block at the heap end
                    ram_we        = 1'b1;
                    ram_waddr     = count_reg[ABITS-1:0];
                    ram_wdata     = {1'b0, used_reg, req_reg};
                    used_next     = need[AW-1:0];
                    count_next    = count_inc;
                    res_st_next   = ffba_pkg::ST_OK;
                    res_addr_next = base_reg + used_reg + HDR;
                end
                state_next = ffba_pkg::S_OUT;
            end
            ffba_pkg::S_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ffba_pkg::S_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= 32'd4096;
            limit_reg     <= 32'd1048576;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                if (cfg_index == ffba_pkg::CFG_HEAP_BASE) begin
                    base_reg <= cfg_data;
                end else if (cfg_index == ffba_pkg::CFG_HEAP_LIMIT) begin
                    limit_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser[0];
            req_reg <= s_tdata[23:0];
            rel_reg <= s_tdata[55:24];
        end
        res_addr_reg  <= res_addr_next;
        res_st_reg    <= res_st_next;
        res_reuse_reg <= res_reuse_next;
        if (out_load) begin
            out_data_reg <= res_addr_reg;
            out_user_reg <= {res_reuse_reg, res_st_reg};
        end
    end

    `FFBA_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_MAX)
    `FFBA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, accept, !s_tready)
    `FFBA_ASSERT_IMP(a_count_step, aclk, aresetn, count_next != count_reg, count_next == count_inc)
    `FFBA_ASSERT_IMP(a_reuse_ok, aclk, aresetn, m_tvalid && m_tuser[2], m_tuser[1:0] == ffba_pkg::ST_OK)

endmodule

/* test/alloc_reply_checker.sv */
`timescale 1ns / 100ps

module alloc_reply_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // request_size[23:0], release_address[55:24]
    input  logic [0:0]  s_tuser,   // op[0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // data_address[31:0]
    input  logic [2:0]  m_tuser,   // status[1:0], reused[2]

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,

    output int          mismatches,
    output int          outstanding
);

    localparam int TABLE_DEPTH = ffba_pkg::MAX_BLOCKS_DEF;
    localparam logic [31:0] HDR = 32'(ffba_pkg::HEADER_BYTES_DEF);

    typedef struct {
        logic [31:0]                   addr;
        logic [ffba_pkg::STATUS_W-1:0] status;
        logic                          reused;
    } alloc_reply_t;

    alloc_reply_t expected_replies[$];

    // mirror of the block table
    logic [ffba_pkg::SIZE_W-1:0] blk_size [TABLE_DEPTH];
    logic [31:0]                 blk_off  [TABLE_DEPTH];
    bit                          blk_free [TABLE_DEPTH];
    int                          blk_count;
    logic [31:0]                 used_bytes;
    logic [31:0]                 heap_base;
    logic [31:0]                 heap_limit;

    assign outstanding = expected_replies.size();

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic serve_request(input logic op, input logic [ffba_pkg::SIZE_W-1:0] size,
                                 input logic [31:0] rel, output alloc_reply_t rep);
        logic [63:0] need;
        bit          done;
        rep = '{addr: 32'd0, status: ffba_pkg::ST_OK, reused: 1'b0};
        done = 1'b0;
        if (op == ffba_pkg::OP_ALLOC) begin
            // first fit over existing blocks, size kept on reuse
            for (int i = 0; i < blk_count && !done; i++) begin
                if (blk_free[i] && blk_size[i] >= size) begin
                    blk_free[i] = 1'b0;
                    rep.addr = heap_base + blk_off[i] + HDR;
                    rep.reused = 1'b1;
                    done = 1'b1;
                end
            end
            if (!done) begin
                need = 64'(used_bytes) + 64'(HDR) + 64'(size);
                if (blk_count >= TABLE_DEPTH) begin
                    rep.status = ffba_pkg::ST_FULL;
                end else if (need > 64'(heap_limit)) begin
                    rep.status = ffba_pkg::ST_LIMIT;
                end else begin
                    blk_off[blk_count] = used_bytes;
                    blk_size[blk_count] = size;
                    blk_free[blk_count] = 1'b0;
                    rep.addr = heap_base + used_bytes + HDR;
                    used_bytes = need[31:0];
                    blk_count++;
                end
            end
        end else if (rel != 32'd0) begin
            rep.status = ffba_pkg::ST_UNKNOWN;
            // lowest matching entry wins
            for (int i = 0; i < blk_count && !done; i++) begin
                if (heap_base + blk_off[i] + HDR == rel) begin
                    blk_free[i] = 1'b1;
                    rep.status = ffba_pkg::ST_OK;
                    done = 1'b1;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        alloc_reply_t rep;
        alloc_reply_t exp_rep;
        if (!aresetn) begin
            expected_replies.delete();
            blk_count = 0;
            used_bytes = 32'd0;
            heap_base = 32'd4096;
            heap_limit = 32'd1048576;
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ffba_pkg::CFG_HEAP_BASE)
                    heap_base = cfg_data;
                else if (cfg_index == ffba_pkg::CFG_HEAP_LIMIT)
                    heap_limit = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                serve_request(s_tuser[0], s_tdata[23:0], s_tdata[55:24], rep);
                expected_replies.push_back(rep);
            end
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected reply addr %h status %0d",
                                              m_tdata, m_tuser[1:0]));
                end else begin
                    exp_rep = expected_replies.pop_front();
                    if (m_tdata !== exp_rep.addr)
                        report_mismatch($sformatf("data_address got %h expected %h",
                                                  m_tdata, exp_rep.addr));
                    if (m_tuser[1:0] !== exp_rep.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  m_tuser[1:0], exp_rep.status));
                    if (m_tuser[2] !== exp_rep.reused)
                        report_mismatch($sformatf("reused got %b expected %b",
                                                  m_tuser[2], exp_rep.reused));
                end
            end
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam logic [31:0] HDR = 32'(ffba_pkg::HEADER_BYTES_DEF);
    localparam logic [31:0] DEFAULT_BASE = 32'd4096;
    localparam logic [ffba_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_LO = 8'd2;
    localparam logic [ffba_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_HI = 8'hFF;
    localparam int PHASE_ITEMS = 500;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT = 5000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // request_size[23:0], release_address[55:24]
    logic [0:0]  s_tuser;   // op[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // data_address[31:0]
    logic [2:0]  m_tuser;   // status[1:0], reused[2]
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [ffba_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                      cfg_data;

    int mismatches;
    int outstanding;

    // stimulus-side bookkeeping
    logic [31:0] live_offsets[$];   // data offsets from heap base handed out so far
    logic [31:0] heap_base_now;
    int          replies_seen;
    bit          steady;
    bit          long_hold_done;
    int          idle_cycles;

    first_fit_block_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    alloc_reply_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && replies_seen >= 600) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // collect handed-out addresses for later frees
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (m_tuser[1:0] == ffba_pkg::ST_OK && m_tdata != 32'd0 &&
                live_offsets.size() < 256)
                live_offsets.push_back(m_tdata - heap_base_now);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [ffba_pkg::SIZE_W-1:0] size,
                                input logic [31:0] rel);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rel, size};
        s_tuser <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold the input side until every reply is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ffba_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == ffba_pkg::CFG_HEAP_BASE)
            heap_base_now = val;
        @(negedge aclk);
    endtask

    task automatic random_request();
        int          r;
        int          k;
        logic [23:0] size;
        logic [31:0] rel;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                size = 24'($urandom_range(0, 255));
            else if (r < 8)
                size = 24'($urandom_range(0, 65535));
            else if (r == 8)
                size = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
            else
                size = 24'($urandom());
            send_request(ffba_pkg::OP_ALLOC, size, $urandom());
        end else begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                rel = 32'd0;
            end else if (r < 4 || live_offsets.size() == 0) begin
                rel = $urandom();
            end else begin
                k = $urandom_range(0, live_offsets.size() - 1);
                rel = heap_base_now + live_offsets[k];
                if (r == 4)
                    rel = rel + ($urandom_range(0, 1) ? 32'd1 : -HDR);
                else if ($urandom_range(0, 9) < 7)
                    live_offsets.delete(k);
            end
            send_request(ffba_pkg::OP_FREE, 24'($urandom()), rel);
        end
    endtask

    initial begin
        logic [31:0] phase_base [3];
        logic [31:0] phase_limit [3];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        heap_base_now = DEFAULT_BASE;
        replies_seen = 0;
        steady = 1'b0;
        long_hold_done = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // heap limit met exactly, then one block too many
        write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'd116);
        send_request(ffba_pkg::OP_ALLOC, 24'd100, 32'd0);
        send_request(ffba_pkg::OP_ALLOC, 24'd0, 32'd0);
        drain();
        write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        send_request(ffba_pkg::OP_ALLOC, 24'hFFFFFF, 32'd0);
        send_request(ffba_pkg::OP_ALLOC, 24'd0, 32'hFFFF_FFFF);
        send_request(ffba_pkg::OP_FREE, 24'hFFFFFF, 32'd0);
        send_request(ffba_pkg::OP_FREE, 24'd0, 32'hFFFF_FFFF);
        send_request(ffba_pkg::OP_FREE, 24'd0, heap_base_now + 32'd116 + HDR);
        send_request(ffba_pkg::OP_FREE, 24'd0, heap_base_now + 32'd116 + HDR);
        send_request(ffba_pkg::OP_ALLOC, 24'hFFFFFF, 32'd0);
        send_request(ffba_pkg::OP_FREE, 24'd0, heap_base_now + 32'd16777347 + HDR);
        send_request(ffba_pkg::OP_ALLOC, 24'd0, 32'd0);
        drain();
        // moving the base moves every data address, with wraparound
        write_reg(ffba_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
        send_request(ffba_pkg::OP_FREE, 24'd0, heap_base_now + HDR);
        send_request(ffba_pkg::OP_FREE, 24'd0, DEFAULT_BASE + HDR);
        send_request(ffba_pkg::OP_ALLOC, 24'd1, 32'd0);
        drain();
        write_reg(ffba_pkg::CFG_HEAP_BASE, 32'd0);
        send_request(ffba_pkg::OP_FREE, 24'd0, heap_base_now + HDR);
        drain();
        write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'd0);
        send_request(ffba_pkg::OP_ALLOC, 24'd200, 32'd0);
        send_request(ffba_pkg::OP_ALLOC, 24'd100, 32'd0);
        send_request(ffba_pkg::OP_ALLOC, 24'd0, 32'd0);
        drain();
        write_reg(CFG_UNMAPPED_LO, 32'hFFFF_FFFF);
        write_reg(CFG_UNMAPPED_HI, 32'd0);

        phase_base[0] = DEFAULT_BASE;
        phase_limit[0] = 32'h0200_0000;
        phase_base[1] = $urandom();
        phase_limit[1] = 32'hFFFF_FFFF;
        phase_base[2] = 32'hFFFF_FFF0;
        phase_limit[2] = 32'd0;
        for (int p = 0; p < 3; p++) begin
            drain();
            write_reg(ffba_pkg::CFG_HEAP_BASE, phase_base[p]);
            write_reg(ffba_pkg::CFG_HEAP_LIMIT, phase_limit[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady = (n >= 100 && n < 200);
                random_request();
            end
            steady = 1'b0;
        end

        drain();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_ram.sv
sv/first_fit_block_allocator_core.sv
test/alloc_reply_checker.sv
test/tb_top.sv
